// ===== rtl/core/icseq_pkg.sv =====
`timescale 1ns / 1ps
package icseq_pkg;

  localparam int DEF_QUEUE_DEPTH      = 16;
  localparam int DEF_BYTE_STORE_DEPTH = 64;

  // transaction opcodes
  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_PUSH   = 2'd1;
  localparam logic [1:0] OP_EVENT  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // request kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WR    = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_QFULL  = 2'd2;
  localparam logic [1:0] ST_BFULL  = 2'd3;

  // burst commands to the bus controller
  localparam logic [3:0] MC_NONE      = 4'd0;
  localparam logic [3:0] MC_TX_START  = 4'd1;
  localparam logic [3:0] MC_TX_CONT   = 4'd2;
  localparam logic [3:0] MC_TX_STOP   = 4'd3;
  localparam logic [3:0] MC_RX_START  = 4'd4;
  localparam logic [3:0] MC_RX_CONT   = 4'd5;
  localparam logic [3:0] MC_RX_FINISH = 4'd6;
  localparam logic [3:0] MC_TX_ERR    = 4'd7;
  localparam logic [3:0] MC_RX_ERR    = 4'd8;

  // completion notices
  localparam logic [1:0] NT_NONE       = 2'd0;
  localparam logic [1:0] NT_WRITE_DONE = 2'd1;
  localparam logic [1:0] NT_READ_DONE  = 2'd2;
  localparam logic [1:0] NT_ERROR      = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] kind;
    logic [6:0] target_addr;
    logic [7:0] tx_length;
    logic [7:0] rx_length;
    logic [7:0] data_byte;
    logic       master_irq;
    logic       master_error;
    logic [7:0] bus_rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] master_cmd;
    logic [6:0] slave_address;
    logic       read_direction;
    logic [7:0] put_byte;
    logic       put_valid;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [1:0] notify;
    logic       irq_enabled;
  } result_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] addr;
    logic [7:0] txl;
    logic [7:0] rxl;
  } entry_t;

  typedef struct packed {
    logic       capture;
    logic       exec;
    logic [1:0] status;
    logic [3:0] master_cmd;
    logic       addr_en;
    logic       read_dir;
    logic       put_en;
    logic       rx_en;
    logic [1:0] notify;
    logic       irq_enabled;
    logic       q_push;
    logic       q_pop;
    logic       b_push;
    logic       b_take;
    logic       tx_start;
    logic       rd_start;
    logic       rd_from_head;
    logic       tx_dec;
    logic       rx_dec;
    logic       abort;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad_submit;
    logic       q_full;
    logic       q_empty;
    logic       b_full;
    logic       irq;
    logic       err;
    logic [1:0] head_kind;
    logic       head_txl_le1;
    logic       head_rxl_le1;
    logic       tx_le1;
    logic       rx_le1;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/icseq_chan_if.sv =====
`timescale 1ns / 1ps
interface icseq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/icseq_ctrl.sv =====
`timescale 1ns / 1ps
module icseq_ctrl
  import icseq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic {
    C_IDLE,
    C_EXEC
  } ctl_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WNEXT,
    PH_WFINAL,
    PH_RNEXT,
    PH_RFINAL
  } phase_t;

  ctl_t   ctl;
  phase_t phase;
  phase_t phase_next;
  logic   irq_en;
  logic   irq_en_next;

  always_comb begin
    cmd         = '0;
    phase_next  = phase;
    irq_en_next = irq_en;
    in_ready    = (ctl == C_IDLE);
    cmd.capture = in_valid && in_ready;
    cmd.exec    = (ctl == C_EXEC) && stat.out_free;

    unique case (stat.op)
      OP_SUBMIT: begin
        if (stat.bad_submit) begin
          cmd.status = ST_REJECT;
        end else if (stat.q_full) begin
          cmd.status = ST_QFULL;
        end else begin
          cmd.q_push = 1'b1;
        end
      end
      OP_PUSH: begin
        if (stat.b_full) begin
          cmd.status = ST_BFULL;
        end else begin
          cmd.b_push = 1'b1;
        end
      end
      OP_EVENT: begin
        if (stat.irq || phase == PH_IDLE) begin
          if (stat.err && phase != PH_IDLE) begin
            // bus error: error stop, drop the head request and its unsent bytes
            irq_en_next    = 1'b0;
            cmd.master_cmd = (phase == PH_RNEXT || phase == PH_RFINAL) ? MC_RX_ERR
                                                                       : MC_TX_ERR;
            cmd.abort      = 1'b1;
            cmd.notify     = NT_ERROR;
            cmd.q_pop      = 1'b1;
            phase_next     = PH_IDLE;
          end else begin
            unique case (phase)
              PH_IDLE: begin
                if (stat.q_empty) begin
                  irq_en_next = 1'b0;
                end else begin
                  irq_en_next = 1'b1;
                  cmd.addr_en = 1'b1;
                  if (stat.head_kind == KIND_READ) begin
                    cmd.master_cmd   = MC_RX_START;
                    cmd.read_dir     = 1'b1;
                    cmd.rd_start     = 1'b1;
                    cmd.rd_from_head = 1'b1;
                    phase_next       = stat.head_rxl_le1 ? PH_RFINAL : PH_RNEXT;
                  end else begin
                    cmd.master_cmd = MC_TX_START;
                    cmd.put_en     = 1'b1;
                    cmd.b_take     = 1'b1;
                    cmd.tx_start   = 1'b1;
                    phase_next     = stat.head_txl_le1 ? PH_WFINAL : PH_WNEXT;
                  end
                end
              end
              PH_WNEXT: begin
                cmd.master_cmd = MC_TX_CONT;
                cmd.put_en     = 1'b1;
                cmd.b_take     = 1'b1;
                cmd.tx_dec     = 1'b1;
                if (stat.tx_le1) begin
                  phase_next = PH_WFINAL;
                end
              end
              PH_WFINAL: begin
                if (stat.head_kind != KIND_WR) begin
                  cmd.master_cmd = MC_TX_STOP;
                  irq_en_next    = 1'b0;
                  cmd.notify     = NT_WRITE_DONE;
                  cmd.q_pop      = 1'b1;
                  phase_next     = PH_IDLE;
                end else begin
                  // repeated start into the read half
                  cmd.master_cmd = MC_RX_START;
                  cmd.addr_en    = 1'b1;
                  cmd.read_dir   = 1'b1;
                  cmd.rd_start   = 1'b1;
                  phase_next     = stat.rx_le1 ? PH_RFINAL : PH_RNEXT;
                end
              end
              PH_RNEXT: begin
                cmd.master_cmd = MC_RX_CONT;
                cmd.rx_en      = 1'b1;
                cmd.rx_dec     = 1'b1;
                if (stat.rx_le1) begin
                  phase_next = PH_RFINAL;
                end
              end
              PH_RFINAL: begin
                cmd.master_cmd = MC_RX_FINISH;
                cmd.rx_en      = 1'b1;
                irq_en_next    = 1'b0;
                cmd.notify     = NT_READ_DONE;
                cmd.q_pop      = 1'b1;
                phase_next     = PH_IDLE;
              end
              default: begin
                phase_next = PH_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase

    cmd.irq_enabled = irq_en_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl    <= C_IDLE;
      phase  <= PH_IDLE;
      irq_en <= 1'b0;
    end else begin
      unique case (ctl)
        C_IDLE: begin
          if (cmd.capture) begin
            ctl <= C_EXEC;
          end
        end
        C_EXEC: begin
          if (cmd.exec) begin
            ctl    <= C_IDLE;
            phase  <= phase_next;
            irq_en <= irq_en_next;
          end
        end
        default: begin
          ctl <= C_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/icseq_dpath.sv =====
`timescale 1ns / 1ps
module icseq_dpath
  import icseq_pkg::*;
#(
  parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
  parameter int BYTE_STORE_DEPTH = DEF_BYTE_STORE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  item_t    item_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  logic     res_ready,
  output logic     res_valid,
  output result_t  res_data
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int QSW = QCW + 1;
  localparam int BAW = $clog2(BYTE_STORE_DEPTH);
  localparam int BCW = $clog2(BYTE_STORE_DEPTH + 1);
  localparam int BSW = BCW + 1;
  localparam int MW  = (BCW > 8) ? BCW : 8;

  item_t            item_q;
  entry_t           q_mem [QUEUE_DEPTH];
  entry_t           q_rd;
  logic [QAW-1:0]   q_head;
  logic [QCW-1:0]   q_count;
  logic [7:0]       b_mem [BYTE_STORE_DEPTH];
  logic [7:0]       b_rd;
  logic [BAW-1:0]   b_head;
  logic [BCW-1:0]   b_count;
  logic [7:0]       tx_rem;
  logic [7:0]       rx_rem;

  logic [QSW-1:0]   q_sum;
  logic [QAW-1:0]   q_tail;
  logic [QAW-1:0]   q_head_inc;
  logic             q_pop_ok;
  logic [BSW-1:0]   b_sum;
  logic [BAW-1:0]   b_tail;
  logic [BCW-1:0]   flush_n;
  logic [BCW-1:0]   b_adv;
  logic [BSW-1:0]   b_adv_sum;
  logic [BAW-1:0]   b_head_adv;
  logic             b_take_ok;
  logic [7:0]       rd_src;
  entry_t           new_entry;
  result_t          res_next;

  // ring pointer arithmetic, sums stay below twice the depth
  always_comb begin
    q_sum      = QSW'(q_head) + QSW'(q_count);
    q_tail     = (q_sum >= QSW'(QUEUE_DEPTH)) ? QAW'(q_sum - QSW'(QUEUE_DEPTH))
                                              : QAW'(q_sum);
    q_head_inc = (q_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_head + QAW'(1);
    q_pop_ok   = cmd.q_pop && (q_count != '0);

    b_sum      = BSW'(b_head) + BSW'(b_count);
    b_tail     = (b_sum >= BSW'(BYTE_STORE_DEPTH)) ? BAW'(b_sum - BSW'(BYTE_STORE_DEPTH))
                                                   : BAW'(b_sum);
    flush_n    = (MW'(tx_rem) < MW'(b_count)) ? BCW'(tx_rem) : b_count;
    b_adv      = cmd.abort ? flush_n : BCW'(1);
    b_adv_sum  = BSW'(b_head) + BSW'(b_adv);
    b_head_adv = (b_adv_sum >= BSW'(BYTE_STORE_DEPTH))
                 ? BAW'(b_adv_sum - BSW'(BYTE_STORE_DEPTH)) : BAW'(b_adv_sum);
    b_take_ok  = cmd.b_take && (b_count != '0);

    rd_src     = cmd.rd_from_head ? q_rd.rxl : rx_rem;

    new_entry.kind = item_q.kind;
    new_entry.addr = item_q.target_addr;
    new_entry.txl  = (item_q.kind == KIND_READ) ? 8'd0 : item_q.tx_length;
    new_entry.rxl  = (item_q.kind == KIND_WRITE) ? 8'd0 : item_q.rx_length;
  end

  always_comb begin
    stat.op           = item_q.opcode;
    stat.bad_submit   = (item_q.kind == KIND_BAD) ||
                        (item_q.kind == KIND_WRITE && item_q.tx_length == 8'd0) ||
                        (item_q.kind == KIND_READ && item_q.rx_length == 8'd0) ||
                        (item_q.kind == KIND_WR &&
                         (item_q.tx_length == 8'd0 || item_q.rx_length == 8'd0));
    stat.q_full       = (q_count == QCW'(QUEUE_DEPTH));
    stat.q_empty      = (q_count == '0);
    stat.b_full       = (b_count == BCW'(BYTE_STORE_DEPTH));
    stat.irq          = item_q.master_irq;
    stat.err          = item_q.master_error;
    stat.head_kind    = q_rd.kind;
    stat.head_txl_le1 = (q_rd.txl <= 8'd1);
    stat.head_rxl_le1 = (q_rd.rxl <= 8'd1);
    stat.tx_le1       = (tx_rem <= 8'd1);
    stat.rx_le1       = (rx_rem <= 8'd1);
    stat.out_free     = !res_valid || res_ready;
  end

  always_comb begin
    res_next.status         = cmd.status;
    res_next.master_cmd     = cmd.master_cmd;
    res_next.slave_address  = cmd.addr_en ? q_rd.addr : 7'd0;
    res_next.read_direction = cmd.read_dir;
    // an empty byte store puts zero
    res_next.put_byte       = (cmd.put_en && b_count != '0) ? b_rd : 8'd0;
    res_next.put_valid      = cmd.put_en;
    res_next.rx_byte        = cmd.rx_en ? item_q.bus_rx_byte : 8'd0;
    res_next.rx_valid       = cmd.rx_en;
    res_next.notify         = cmd.notify;
    res_next.irq_enabled    = cmd.irq_enabled;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item_data;
    end
  end

  // both stores are read at their heads every cycle, ready by the update cycle
  always_ff @(posedge clk) begin
    q_rd <= q_mem[q_head];
    if (cmd.exec && cmd.q_push) begin
      q_mem[q_tail] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    b_rd <= b_mem[b_head];
    if (cmd.exec && cmd.b_push) begin
      b_mem[b_tail] <= item_q.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_count <= '0;
      b_head  <= '0;
      b_count <= '0;
      tx_rem  <= 8'd0;
      rx_rem  <= 8'd0;
    end else if (cmd.exec) begin
      if (cmd.q_push) begin
        q_count <= q_count + QCW'(1);
      end else if (q_pop_ok) begin
        q_count <= q_count - QCW'(1);
        q_head  <= q_head_inc;
      end

      if (cmd.b_push) begin
        b_count <= b_count + BCW'(1);
      end else if (b_take_ok || cmd.abort) begin
        b_count <= b_count - b_adv;
        b_head  <= b_head_adv;
      end

      if (cmd.abort) begin
        tx_rem <= 8'd0;
        rx_rem <= 8'd0;
      end else if (cmd.tx_start) begin
        tx_rem <= (q_rd.txl != 8'd0) ? q_rd.txl - 8'd1 : 8'd0;
        rx_rem <= q_rd.rxl;
      end else if (cmd.rd_start) begin
        tx_rem <= 8'd0;
        rx_rem <= (rd_src != 8'd0) ? rd_src - 8'd1 : 8'd0;
      end else begin
        if (cmd.tx_dec && tx_rem != 8'd0) begin
          tx_rem <= tx_rem - 8'd1;
        end
        if (cmd.rx_dec && rx_rem != 8'd0) begin
          rx_rem <= rx_rem - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.exec) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_data <= res_next;
    end
  end

endmodule

// ===== rtl/core/i2c_transaction_sequencer_core.sv =====
`timescale 1ns / 1ps
// I2C master transaction sequencer: submit transactions queue write, read or
// write-then-read requests, push transactions feed the shared transmit byte
// store, and event transactions step the bus phases, each answered by exactly
// one result carrying the burst command, address, byte to put, received byte,
// completion notice and interrupt enable. Every transaction is first captured
// while both stores are read at their heads, then updates state and loads the
// result register; the registered store reads are why capture and update are
// separate. The next transaction is captured while a result still waits; its
// update cycle is held until the result register is free, and no further
// transaction is taken meanwhile. Store contents are undefined until written;
// reset clears the pointers and counts, not the store contents.
module i2c_transaction_sequencer_core
  import icseq_pkg::*;
#(
  parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
  parameter int BYTE_STORE_DEPTH = DEF_BYTE_STORE_DEPTH
) (
  input logic          clk,
  input logic          rst,
  icseq_chan_if.sink   item,
  icseq_chan_if.source result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     res_valid;
  result_t  res_data;

  icseq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  icseq_dpath #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .BYTE_STORE_DEPTH (BYTE_STORE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item_data (item.data),
    .cmd       (cmd),
    .stat      (stat),
    .res_ready (result.ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign item.ready   = in_ready;
  assign result.valid = res_valid;
  assign result.data  = res_data;

endmodule
